/* rtl/pwl_pkg.sv */
// Shared constants, types and segment tables for the piecewise-linear curve.
`timescale 1ns / 1ps
`default_nettype none

package pwl_pkg;

  localparam int NUM_POINTS  = 32;
  localparam int IDX_W       = $clog2(NUM_POINTS);
  localparam int POS_W       = 13;
  localparam int VAL_W       = 16;
  localparam int OFF_W       = 10;   // widest segment is 1000 positions
  localparam int WID_W       = 10;
  localparam int RECIP_W     = 22;
  localparam int RECIP_SHIFT = 26;
  localparam int MAG_W       = 26;   // |(v1-v0)*offset| < 2^26
  localparam int PROD_W      = 28;
  localparam int QUO_W       = 22;
  localparam int REM_W       = 11;   // remainder before correction < 2*width
  localparam int SUM_W       = 24;

  localparam logic [POS_W-1:0] TOP_LEVEL = 13'd5700;

  // Fixed breakpoint positions; also the reset content of the value store.
  localparam logic [POS_W-1:0] BP_POS [NUM_POINTS] = '{
    13'd20,   13'd40,   13'd60,   13'd80,   13'd100,
    13'd120,  13'd140,  13'd160,  13'd180,  13'd200,
    13'd250,  13'd300,  13'd350,  13'd400,  13'd450,  13'd500,
    13'd600,  13'd700,  13'd800,  13'd900,  13'd1000,
    13'd1200, 13'd1400, 13'd1600, 13'd1800, 13'd2000,
    13'd2500, 13'd3000, 13'd3500, 13'd4000,
    13'd5000, 13'd5700
  };

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [VAL_W-1:0] val_t;

  // Segment request handed from the front end to the interpolator.
  // seg is the index of the upper breakpoint; seg 0 starts from zero.
  typedef struct packed {
    logic             top;
    logic [IDX_W-1:0] seg;
    logic [OFF_W-1:0] offset;
  } seg_req_t;

  // Lower end of a segment
  function automatic logic [POS_W-1:0] seg_base(input logic [IDX_W-1:0] seg);
    logic [POS_W-1:0] b;
    b = '0;
    if (seg != '0) b = BP_POS[seg - 1'b1];
    return b;
  endfunction

  // Segment width
  function automatic logic [WID_W-1:0] seg_width(input logic [IDX_W-1:0] seg);
    logic [WID_W-1:0] w;
    case (seg) inside
      [5'd0:5'd9]:   w = 10'd20;
      [5'd10:5'd15]: w = 10'd50;
      [5'd16:5'd20]: w = 10'd100;
      [5'd21:5'd25]: w = 10'd200;
      [5'd26:5'd29]: w = 10'd500;
      5'd30:         w = 10'd1000;
      default:       w = 10'd700;   // last segment, 5000 to top
    endcase
    return w;
  endfunction

  // floor(2^26 / width) per segment
  function automatic logic [RECIP_W-1:0] seg_recip(input logic [IDX_W-1:0] seg);
    logic [RECIP_W-1:0] r;
    case (seg) inside
      [5'd0:5'd9]:   r = 22'd3355443;
      [5'd10:5'd15]: r = 22'd1342177;
      [5'd16:5'd20]: r = 22'd671088;
      [5'd21:5'd25]: r = 22'd335544;
      [5'd26:5'd29]: r = 22'd134217;
      5'd30:         r = 22'd67108;
      default:       r = 22'd95869;   // last segment, width 700
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/pwl_mem.sv */
// Breakpoint value store: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module pwl_mem (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          we,
  input  wire pwl_pkg::idx_t waddr,
  input  wire pwl_pkg::val_t wdata,
  input  wire pwl_pkg::idx_t raddr_a,
  input  wire pwl_pkg::idx_t raddr_b,
  output pwl_pkg::val_t      rdata_a,
  output pwl_pkg::val_t      rdata_b
);
  import pwl_pkg::*;

  val_t                  mem [NUM_POINTS];
  logic [NUM_POINTS-1:0] written;

  // Valid bit is set when an entry is written; reset clears all bits
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (we) begin
      written[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Unwritten entries read as their breakpoint position
  always_ff @(posedge clk) begin
    rdata_a <= written[raddr_a] ? mem[raddr_a] : VAL_W'(BP_POS[raddr_a]);
    rdata_b <= written[raddr_b] ? mem[raddr_b] : VAL_W'(BP_POS[raddr_b]);
  end

endmodule

`default_nettype wire

/* rtl/pwl_interp.sv */
// Interpolation datapath: multiply, reciprocal divide and floor correction.
`timescale 1ns / 1ps
`default_nettype none

module pwl_interp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire pwl_pkg::seg_req_t req,
  input  wire pwl_pkg::val_t     v_lo,
  input  wire pwl_pkg::val_t     v_hi,
  output logic                   done,
  output pwl_pkg::val_t          result
);
  import pwl_pkg::*;

  logic v1, v2, v3;

  // stage 1 registers
  logic signed [PROD_W-1:0] prod1;
  val_t                     vlo1;
  logic [IDX_W-1:0]         seg1;
  logic                     top1;
  // stage 2 registers
  logic [MAG_W-1:0]         mag2;
  logic [QUO_W-1:0]         q0_2;
  logic                     neg2;
  val_t                     vlo2;
  logic [IDX_W-1:0]         seg2;
  logic                     top2;
  // stage 3 registers
  logic [REM_W-1:0]         rem3;
  logic [QUO_W-1:0]         q0_3;
  logic                     neg3;
  val_t                     vlo3;
  logic [IDX_W-1:0]         seg3;
  logic                     top3;

  val_t                     vlo_eff;
  logic signed [VAL_W:0]    diff;
  logic signed [PROD_W-1:0] prod_c;
  logic [PROD_W-1:0]        abs_c;
  logic [47:0]              mr_c;
  logic [31:0]              qw_c;
  logic [31:0]              rem_full;
  logic [WID_W-1:0]         w3;
  logic                     ge;
  logic [REM_W-1:0]         r_fix;
  logic [SUM_W-1:0]         q_mag;
  logic [SUM_W-1:0]         quot;
  logic [SUM_W-1:0]         sum;

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage 1: slope times offset; below the first breakpoint start from zero
  always_comb begin
    vlo_eff = (req.seg == '0) ? '0 : v_lo;
    diff    = $signed({1'b0, v_hi}) - $signed({1'b0, vlo_eff});
    prod_c  = diff * $signed({1'b0, req.offset});
  end

  always_ff @(posedge clk) begin
    prod1 <= prod_c;
    vlo1  <= vlo_eff;
    seg1  <= req.seg;
    top1  <= req.top;
  end

  // Stage 2: magnitude times reciprocal gives a quotient estimate
  always_comb begin
    abs_c = prod1[PROD_W-1] ? PROD_W'(-prod1) : PROD_W'(prod1);
    mr_c  = 48'(abs_c[MAG_W-1:0]) * 48'(seg_recip(seg1));
  end

  always_ff @(posedge clk) begin
    mag2 <= abs_c[MAG_W-1:0];
    q0_2 <= mr_c[RECIP_SHIFT +: QUO_W];
    neg2 <= prod1[PROD_W-1];
    vlo2 <= vlo1;
    seg2 <= seg1;
    top2 <= top1;
  end

  // Stage 3: remainder of the estimate, below twice the width
  always_comb begin
    qw_c     = 32'(q0_2) * 32'(seg_width(seg2));
    rem_full = 32'(mag2) - qw_c;
  end

  always_ff @(posedge clk) begin
    rem3 <= rem_full[REM_W-1:0];
    q0_3 <= q0_2;
    neg3 <= neg2;
    vlo3 <= vlo2;
    seg3 <= seg2;
    top3 <= top2;
  end

  // Correction, floor toward minus infinity, add the lower value
  always_comb begin
    w3    = seg_width(seg3);
    ge    = rem3 >= REM_W'(w3);
    r_fix = ge ? (rem3 - REM_W'(w3)) : rem3;
    q_mag = SUM_W'(q0_3) + SUM_W'(ge) + SUM_W'(neg3 && (r_fix != '0));
    quot  = neg3 ? (~q_mag + 1'b1) : q_mag;
    sum   = SUM_W'(vlo3) + quot;
  end

  assign done   = v3;
  assign result = top3 ? VAL_W'(TOP_LEVEL) : sum[VAL_W-1:0];

endmodule

`default_nettype wire

/* rtl/piecewise_linear_curve.sv */
// Piecewise-linear dimming curve: top level with input decode and result buffer.
//
// Input channel (in_valid/in_ready) carries one beat per item. kind 0 loads
// point_value into breakpoint point_index and gives no result; kind 1 evaluates
// the curve at position and gives one beat on the output channel
// (out_valid/out_ready) with the level.
// An evaluate beat passes the value read, multiply, reciprocal multiply,
// remainder, then the output register before its level shows on the output.
// One evaluate is in flight at a time; the next item may be accepted in the
// cycle the result is written, so a new evaluate is not taken before the last
// one is through. A load is accepted only when the datapath is idle or done.
// Reset clears the output and all breakpoint valid bits at once, so every
// value reads back as its breakpoint position (identity curve); no clearing
// pass is needed.
// When the receiver stalls, a finished level waits in the output register and
// a second one in a holding register; input is also refused while that is full.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_curve (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [4:0]  point_index,
  input  wire logic [15:0] point_value,
  input  wire logic [12:0] position,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      level
);
  import pwl_pkg::*;

  logic       accept;
  logic       eval_acc;
  logic       load_acc;
  logic       busy;
  logic       fetch;
  seg_req_t   req_c;
  seg_req_t   req;
  idx_t       seg_c;
  val_t       rd_lo;
  val_t       rd_hi;
  logic       done;
  val_t       res;
  logic       pend_valid;
  val_t       pend_level;
  logic       out_free;
  logic       from_pend;
  logic       from_res;
  logic       to_pend;

  assign accept   = in_valid && in_ready;
  assign eval_acc = accept && kind;
  assign load_acc = accept && !kind;

  // Segment search over the fixed positions: upper breakpoint index
  always_comb begin
    seg_c = '0;
    for (int i = 0; i < NUM_POINTS - 1; i++) begin
      if (position >= BP_POS[i]) seg_c = IDX_W'(i + 1);
    end
    req_c.seg    = seg_c;
    req_c.top    = position >= TOP_LEVEL;
    req_c.offset = OFF_W'(position - seg_base(seg_c));
  end

  pwl_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .we      (load_acc),
    .waddr   (point_index),
    .wdata   (point_value),
    .raddr_a (seg_c - 1'b1),
    .raddr_b (seg_c),
    .rdata_a (rd_lo),
    .rdata_b (rd_hi)
  );

  // Segment request lines up with the registered read data
  always_ff @(posedge clk) begin
    if (eval_acc) req <= req_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fetch <= 1'b0;
      busy  <= 1'b0;
    end else begin
      fetch <= eval_acc;
      if (eval_acc) busy <= 1'b1;
      else if (done) busy <= 1'b0;
    end
  end

  pwl_interp u_interp (
    .clk    (clk),
    .rst    (rst),
    .start  (fetch),
    .req    (req),
    .v_lo   (rd_lo),
    .v_hi   (rd_hi),
    .done   (done),
    .result (res)
  );

  // Output register with one holding slot behind it
  assign out_free  = !out_valid || out_ready;
  assign from_pend = pend_valid && out_free;
  assign from_res  = done && !pend_valid && out_free;
  assign to_pend   = done && !pend_valid && !out_free;

  assign in_ready = (!busy || done) && !pend_valid && !to_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (from_pend || from_res) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (from_pend) pend_valid <= 1'b0;
      else if (to_pend) pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (from_pend) level <= pend_level;
    else if (from_res) level <= res;
    if (to_pend) pend_level <= res;
  end

endmodule

`default_nettype wire

/* tb/piecewise_linear_curve_test.sv */
// Self-checking testbench for piecewise_linear_curve: directed and random load/evaluate traffic.
`timescale 1ns / 1ps

module piecewise_linear_curve_test;
  import pwl_pkg::*;

  typedef enum logic {KIND_LOAD = 1'b0, KIND_EVAL = 1'b1} item_kind_t;

  localparam int RANDOM_ITEMS = 700;
  localparam int MAX_GAP      = 12;
  localparam int IDLE_LIMIT   = 1000;
  localparam int TAIL_CYCLES  = 12;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        kind;
  logic [4:0]  point_index;
  logic [15:0] point_value;
  logic [12:0] position;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] level;

  // Predictor state: stored breakpoint values and levels still owed by the block
  val_t curve_store [NUM_POINTS];
  val_t level_expect_q [$];
  val_t level_exp;
  int   mismatch_count = 0;
  int   idle_cycles = 0;
  bit   sender_steady = 1'b0;
  bit   receiver_steady = 1'b0;

  piecewise_linear_curve u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .point_index(point_index),
    .point_value(point_value),
    .position   (position),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .level      (level)
  );

  // 12 ns clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Interpolated level at a position for the current stored values
  function automatic val_t predict_level(input logic [12:0] pos);
    int     seg;
    longint lo_v, hi_v, lo_b, hi_b, num, den, quot, r;
    if (pos >= TOP_LEVEL) return val_t'(TOP_LEVEL);
    if (pos < BP_POS[0]) begin
      r = longint'(curve_store[0]) * longint'(pos) / longint'(BP_POS[0]);
      return val_t'(r);
    end
    seg = 0;
    while (seg + 2 < NUM_POINTS && pos >= BP_POS[seg + 1]) seg++;
    lo_v = longint'(curve_store[seg]);
    hi_v = longint'(curve_store[seg + 1]);
    lo_b = longint'(BP_POS[seg]);
    hi_b = longint'(BP_POS[seg + 1]);
    num  = (hi_v - lo_v) * (longint'(pos) - lo_b);
    den  = hi_b - lo_b;
    // floor division, rounds toward minus infinity on falling segments
    if (num >= 0) quot = num / den;
    else quot = -((-num + den - 1) / den);
    r = lo_v + quot;
    if (r < 0) r = 0;
    if (r > 65535) r = 65535;
    return val_t'(r);
  endfunction

  // Position mix: mostly in range, some near breakpoints, some above top
  function automatic logic [12:0] pick_position();
    int k;
    case ($urandom_range(0, 9))
      0: return 13'($urandom);
      1, 2: begin
        k = $urandom_range(0, NUM_POINTS - 1);
        return 13'(int'(BP_POS[k]) + int'($urandom_range(0, 2)) - 1);
      end
      3: return 13'($urandom_range(0, 19));
      default: return 13'($urandom_range(0, 5699));
    endcase
  endfunction

  // Value mix for a load: extremes, near identity, or anything
  function automatic val_t pick_value(input int idx);
    case ($urandom_range(0, 6))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return val_t'(int'(BP_POS[idx]) + int'($urandom_range(0, 400)));
      default: return val_t'($urandom);
    endcase
  endfunction

  // Send one input beat after a random gap; update the predictor on acceptance
  task automatic send_item(input item_kind_t k, input idx_t idx, input val_t val,
                           input logic [12:0] pos);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    kind        <= k;
    point_index <= idx;
    point_value <= val;
    position    <= pos;
    do @(posedge clk); while (!in_ready);
    if (k == KIND_LOAD) curve_store[idx] = val;
    else level_expect_q.push_back(predict_level(pos));
  endtask

  // Unused fields carry random content
  task automatic load_point(input int idx, input val_t val);
    send_item(KIND_LOAD, idx_t'(idx), val, 13'($urandom));
  endtask

  task automatic eval_at(input logic [12:0] pos);
    send_item(KIND_EVAL, idx_t'($urandom), val_t'($urandom), pos);
  endtask

  // Hold off the sender until every owed level has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (level_expect_q.size() != 0) @(posedge clk);
  endtask

  // Identity curve after reset, edges of the position range
  task automatic test_reset_identity();
    eval_at(13'd0);
    eval_at(13'd19);
    eval_at(13'd20);
    eval_at(13'd21);
    eval_at(13'd2750);
    eval_at(13'd5699);
    eval_at(13'd5700);
    eval_at(13'h1FFF);
  endtask

  // Extreme stored values, steep rising and falling segments
  task automatic test_extreme_points();
    load_point(0, 16'hFFFF);
    load_point(1, 16'h0000);
    eval_at(13'd10);
    eval_at(13'd25);
    load_point(30, 16'h0000);
    load_point(31, 16'hFFFF);
    eval_at(13'd5350);
    eval_at(13'd5699);
    // falling segment between 500 and 600
    load_point(15, 16'hFFFF);
    load_point(16, 16'h0000);
    eval_at(13'd501);
    eval_at(13'd550);
    eval_at(13'd599);
    // top is fixed whatever the stored values
    eval_at(13'd5700);
    eval_at(13'd6000);
  endtask

  // Short bursts, each followed by a full drain
  task automatic test_drain_pause();
    int round, i;
    for (round = 0; round < 3; round++) begin
      for (i = 0; i < 8; i++) begin
        if ($urandom_range(0, 2) == 0) begin
          load_point($urandom_range(0, NUM_POINTS - 1), val_t'($urandom));
        end else begin
          eval_at(pick_position());
        end
      end
      drain_results();
    end
  endtask

  // Random mix of loads and evaluates with changing idle patterns
  task automatic test_random_traffic();
    int i, idx;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 60 == 0) begin
        sender_steady   = ($urandom_range(0, 3) == 0);
        receiver_steady = ($urandom_range(0, 3) == 0);
      end
      if (i == RANDOM_ITEMS / 2) drain_results();
      if ($urandom_range(0, 99) < 60) begin
        eval_at(pick_position());
      end else begin
        idx = $urandom_range(0, NUM_POINTS - 1);
        load_point(idx, pick_value(idx));
      end
    end
  endtask

  // Receiver: random stall before each result beat
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = receiver_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each result beat with the oldest owed level
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (level_expect_q.size() == 0) begin
        $display("%0t: unexpected level beat, actual %0d", $time, level);
        mismatch_count++;
      end else begin
        level_exp = level_expect_q.pop_front();
        if (level !== level_exp) begin
          $display("%0t: level mismatch, expected %0d, actual %0d", $time, level_exp, level);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, no beat for %0d cycles", $time, idle_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Main sequence
  initial begin
    int i;
    rst         = 1'b1;
    in_valid    = 1'b0;
    kind        = KIND_LOAD;
    point_index = '0;
    point_value = '0;
    position    = '0;
    for (i = 0; i < NUM_POINTS; i++) curve_store[i] = val_t'(BP_POS[i]);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_identity();
    test_extreme_points();
    test_drain_pause();
    test_random_traffic();

    @(negedge clk);
    in_valid <= 1'b0;
    while (level_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && level_expect_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
